// File: hw/rtl/snh_pkg.sv
package snh_pkg;

   localparam logic [31:0] MURMUR_M = 32'h5bd1e995;

   localparam logic [5:0] SH_JENKINS_ADD   = 6'd10;
   localparam logic [5:0] SH_JENKINS_XOR   = 6'd6;
   localparam logic [5:0] SH_JENKINS_FIN_A = 6'd3;
   localparam logic [5:0] SH_JENKINS_FIN_B = 6'd11;
   localparam logic [5:0] SH_JENKINS_FIN_C = 6'd15;
   localparam logic [5:0] SH_XOR33         = 6'd5;
   localparam logic [5:0] SH_MURMUR_K      = 6'd24;
   localparam logic [5:0] SH_MURMUR_FIN_A  = 6'd13;
   localparam logic [5:0] SH_MURMUR_FIN_B  = 6'd15;

   localparam logic [1:0] CSR_MODE_JENKINS = 2'd0;
   localparam logic [1:0] CSR_MODE_MURMUR  = 2'd1;

   typedef enum logic [1:0] {
      MODE_JENKINS = 2'd0,
      MODE_MURMUR  = 2'd1,
      MODE_XOR33   = 2'd2
   } mode_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_J_ADD,
      ST_J_SHL10,
      ST_J_SHR6,
      ST_D_SHL5,
      ST_D_XORB,
      ST_M_K1LO,
      ST_M_K1HI,
      ST_M_K24,
      ST_M_K2LO,
      ST_M_K2HI,
      ST_M_HLO,
      ST_M_HHI,
      ST_M_HXK,
      ST_F0_SHL3,
      ST_F0_SHR11,
      ST_F0_SHL15,
      ST_F1_SHR13,
      ST_F1_LO,
      ST_F1_HI,
      ST_F1_SHR15,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      ALU_ADD_B,
      ALU_ADD_SHL,
      ALU_XOR_SHR,
      ALU_XOR_B,
      ALU_MUL_LO,
      ALU_MUL_HI
   } alu_op_type;

   typedef enum logic {
      SRC_H,
      SRC_K
   } src_type;

   typedef enum logic [1:0] {
      BSEL_BYTE,
      BSEL_K,
      BSEL_P
   } bsel_type;

   typedef enum logic [1:0] {
      DST_NONE,
      DST_H,
      DST_K,
      DST_P
   } dst_type;

   typedef struct packed {
      alu_op_type op;
      src_type    src;
      bsel_type   bsel;
      logic [5:0] shamt;
      dst_type    dst;
      logic       clr_k;
      logic       load_out;
   } ctl_type;

   typedef struct packed {
      logic     req_fire;
      mode_type mode;
      logic     take;
      logic     mix_now;
      logic     last;
      logic     last_ff;
      logic     out_free;
   } status_type;

   function automatic mode_type map_mode(input logic [1:0] csr_mode);
      mode_type m;
      case (csr_mode)
         CSR_MODE_JENKINS: m = MODE_JENKINS;
         CSR_MODE_MURMUR:  m = MODE_MURMUR;
         default:          m = MODE_XOR33;
      endcase
      return m;
   endfunction

endpackage

// File: hw/rtl/selectable_name_hash.sv
// Each hashed byte runs add, shift-add and xor-shift steps in Jenkins mode, shift-add and xor
// steps in multiply-33 mode, and each completed 8-byte word runs the Murmur mix, all on one
// shared 64-bit ALU with a single 32x32 multiplier (two passes per 64-bit product). The last
// request adds finalization in Jenkins and Murmur mode (Murmur first mixes any partial word).
// A new request is taken only after the previous one is done, and result stalls hold it back.
// Reset is synchronous and active high; it clears control state and sets hash_mode to 0.
module selectable_name_hash #(
   parameter int MAX_HASHED_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_name_length,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_name_hash
);

   localparam int MURMUR_LIMIT = (MAX_HASHED_BYTES + 7) / 8 * 8;
   localparam int CW           = $clog2(MURMUR_LIMIT + 1);

   logic [1:0]          mode_cfg_ff;
   logic                open_ff;
   logic                last_ff;
   snh_pkg::mode_type   mode_ff;
   logic [15:0]         len_ff;
   logic [CW-1:0]       cnt_ff;
   logic [7:0]          byte_ff;
   logic [63:0]         h_ff;
   logic [63:0]         k_ff;
   logic [63:0]         p_ff;
   logic                rsp_valid_ff;
   logic [63:0]         rsp_hash_ff;

   snh_pkg::mode_type   mode_eff;
   logic [15:0]         len_eff;
   logic [CW-1:0]       cnt_eff;
   logic [CW-1:0]       cnt_in;
   logic [CW-1:0]       limit_eff;
   logic [63:0]         h_eff;
   logic [63:0]         k_eff;
   logic [63:0]         k_gather;
   logic [2:0]          idx;
   logic                take;
   logic                mix_now;
   logic                req_fire;
   logic                out_free;
   logic                seq_idle;
   logic [63:0]         alu_a;
   logic [63:0]         alu_b;
   logic [63:0]         alu_y;
   snh_pkg::ctl_type    ctl;
   snh_pkg::status_type status;

   assign req_fire = req_valid && !req_stall;
   assign req_stall = !seq_idle;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_name_hash = rsp_hash_ff;

   always_comb begin
      if (open_ff) begin
         mode_eff = mode_ff;
         len_eff  = len_ff;
         cnt_eff  = cnt_ff;
         h_eff    = h_ff;
         k_eff    = k_ff;
      end else begin
         mode_eff = snh_pkg::map_mode(mode_cfg_ff);
         len_eff  = req_name_length;
         cnt_eff  = '0;
         h_eff    = (mode_eff == snh_pkg::MODE_MURMUR)
                    ? ({32'b0, snh_pkg::MURMUR_M} ^ {48'b0, req_name_length}) : 64'b0;
         k_eff    = '0;
      end
   end

   assign limit_eff = (mode_eff == snh_pkg::MODE_MURMUR) ? CW'(MURMUR_LIMIT)
                                                          : CW'(MAX_HASHED_BYTES);
   assign take = req_byte_valid && (16'(cnt_eff) < len_eff) && (cnt_eff < limit_eff);
   assign idx = cnt_eff[2:0];
   assign cnt_in = take ? cnt_eff + CW'(1) : cnt_eff;
   assign k_gather = take ? (k_eff | ({56'b0, req_data_byte} << {idx, 3'b000})) : k_eff;
   assign mix_now = (take && (idx == 3'd7)) || (req_last_byte && (cnt_in[2:0] != 3'd0));

   assign status.req_fire = req_fire;
   assign status.mode     = mode_eff;
   assign status.take     = take;
   assign status.mix_now  = mix_now;
   assign status.last     = req_last_byte;
   assign status.last_ff  = last_ff;
   assign status.out_free = out_free;

   snh_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl),
      .idle   (seq_idle)
   );

   always_comb begin
      alu_a = (ctl.src == snh_pkg::SRC_K) ? k_ff : h_ff;
      case (ctl.bsel)
         snh_pkg::BSEL_K: alu_b = k_ff;
         snh_pkg::BSEL_P: alu_b = p_ff;
         default:         alu_b = {56'b0, byte_ff};
      endcase
   end

   snh_alu u_alu (
      .op    (ctl.op),
      .a     (alu_a),
      .b     (alu_b),
      .shamt (ctl.shamt),
      .y     (alu_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_cfg_ff  <= snh_pkg::CSR_MODE_JENKINS;
         open_ff      <= 1'b0;
         last_ff      <= 1'b0;
         mode_ff      <= snh_pkg::MODE_JENKINS;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            mode_cfg_ff <= csr_write_data;
         end
         if (req_fire) begin
            open_ff <= !req_last_byte;
            last_ff <= req_last_byte;
            mode_ff <= mode_eff;
            cnt_ff  <= cnt_in;
         end
         if (ctl.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         len_ff  <= len_eff;
         byte_ff <= req_data_byte;
         h_ff    <= h_eff;
         k_ff    <= k_gather;
      end else begin
         case (ctl.dst)
            snh_pkg::DST_H: h_ff <= alu_y;
            snh_pkg::DST_K: k_ff <= alu_y;
            snh_pkg::DST_P: p_ff <= alu_y;
            default: ;
         endcase
         if (ctl.clr_k) begin
            k_ff <= '0;
         end
      end
      if (ctl.load_out) begin
         rsp_hash_ff <= h_ff;
      end
   end

`ifndef SYNTHESIS
   // A loaded result appears on the output with the finished accumulator.
   a_load_out: assert property (@(posedge clock) disable iff (reset)
      ctl.load_out |=> rsp_valid && (rsp_name_hash == $past(h_ff)))
      else $error("result register not loaded from accumulator");

   // The last request of a name always closes it and starts a busy sequence.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_last_byte) |=> (req_stall && !open_ff))
      else $error("last request did not close the name");

   // Between requests in Murmur mode the word buffer is empty on a word boundary.
   a_word_clear: assert property (@(posedge clock) disable iff (reset)
      (seq_idle && open_ff && (mode_ff == snh_pkg::MODE_MURMUR) && (cnt_ff[2:0] == 3'd0))
      |-> (k_ff == 64'b0))
      else $error("word buffer not cleared after mix");
`endif

endmodule

// File: hw/rtl/snh_alu.sv
module snh_alu (
   input  snh_pkg::alu_op_type op,
   input  logic [63:0]         a,
   input  logic [63:0]         b,
   input  logic [5:0]          shamt,
   output logic [63:0]         y
);

   logic [31:0] mul_in;
   logic [63:0] prod;

   assign mul_in = (op == snh_pkg::ALU_MUL_HI) ? a[63:32] : a[31:0];
   assign prod   = mul_in * snh_pkg::MURMUR_M;

   always_comb begin
      case (op)
         snh_pkg::ALU_ADD_B:   y = a + b;
         snh_pkg::ALU_ADD_SHL: y = a + (a << shamt);
         snh_pkg::ALU_XOR_SHR: y = a ^ (a >> shamt);
         snh_pkg::ALU_XOR_B:   y = a ^ b;
         snh_pkg::ALU_MUL_LO:  y = prod;
         snh_pkg::ALU_MUL_HI:  y = {b[63:32] + prod[31:0], b[31:0]};
         default:              y = a;
      endcase
   end

endmodule

// File: hw/rtl/snh_seq.sv
module snh_seq (
   input  logic                clock,
   input  logic                reset,
   input  snh_pkg::status_type status,
   output snh_pkg::ctl_type    ctl,
   output logic                idle
);

   snh_pkg::state_type state_ff;
   snh_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= snh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         snh_pkg::ST_IDLE: begin
            if (status.req_fire) begin
               case (status.mode)
                  snh_pkg::MODE_JENKINS: begin
                     if (status.take)      state_in = snh_pkg::ST_J_ADD;
                     else if (status.last) state_in = snh_pkg::ST_F0_SHL3;
                  end
                  snh_pkg::MODE_MURMUR: begin
                     if (status.mix_now)   state_in = snh_pkg::ST_M_K1LO;
                     else if (status.last) state_in = snh_pkg::ST_F1_SHR13;
                  end
                  default: begin
                     if (status.take)      state_in = snh_pkg::ST_D_SHL5;
                     else if (status.last) state_in = snh_pkg::ST_DONE;
                  end
               endcase
            end
         end
         snh_pkg::ST_J_ADD:    state_in = snh_pkg::ST_J_SHL10;
         snh_pkg::ST_J_SHL10:  state_in = snh_pkg::ST_J_SHR6;
         snh_pkg::ST_J_SHR6:
            state_in = status.last_ff ? snh_pkg::ST_F0_SHL3 : snh_pkg::ST_IDLE;
         snh_pkg::ST_D_SHL5:   state_in = snh_pkg::ST_D_XORB;
         snh_pkg::ST_D_XORB:
            state_in = status.last_ff ? snh_pkg::ST_DONE : snh_pkg::ST_IDLE;
         snh_pkg::ST_M_K1LO:   state_in = snh_pkg::ST_M_K1HI;
         snh_pkg::ST_M_K1HI:   state_in = snh_pkg::ST_M_K24;
         snh_pkg::ST_M_K24:    state_in = snh_pkg::ST_M_K2LO;
         snh_pkg::ST_M_K2LO:   state_in = snh_pkg::ST_M_K2HI;
         snh_pkg::ST_M_K2HI:   state_in = snh_pkg::ST_M_HLO;
         snh_pkg::ST_M_HLO:    state_in = snh_pkg::ST_M_HHI;
         snh_pkg::ST_M_HHI:    state_in = snh_pkg::ST_M_HXK;
         snh_pkg::ST_M_HXK:
            state_in = status.last_ff ? snh_pkg::ST_F1_SHR13 : snh_pkg::ST_IDLE;
         snh_pkg::ST_F0_SHL3:  state_in = snh_pkg::ST_F0_SHR11;
         snh_pkg::ST_F0_SHR11: state_in = snh_pkg::ST_F0_SHL15;
         snh_pkg::ST_F0_SHL15: state_in = snh_pkg::ST_DONE;
         snh_pkg::ST_F1_SHR13: state_in = snh_pkg::ST_F1_LO;
         snh_pkg::ST_F1_LO:    state_in = snh_pkg::ST_F1_HI;
         snh_pkg::ST_F1_HI:    state_in = snh_pkg::ST_F1_SHR15;
         snh_pkg::ST_F1_SHR15: state_in = snh_pkg::ST_DONE;
         snh_pkg::ST_DONE:
            state_in = status.out_free ? snh_pkg::ST_IDLE : snh_pkg::ST_DONE;
         default:              state_in = snh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl.op       = snh_pkg::ALU_XOR_SHR;
      ctl.src      = snh_pkg::SRC_H;
      ctl.bsel     = snh_pkg::BSEL_BYTE;
      ctl.shamt    = '0;
      ctl.dst      = snh_pkg::DST_NONE;
      ctl.clr_k    = 1'b0;
      ctl.load_out = 1'b0;
      idle         = 1'b0;
      case (state_ff)
         snh_pkg::ST_IDLE: idle = 1'b1;
         snh_pkg::ST_J_ADD: begin
            ctl.op  = snh_pkg::ALU_ADD_B;
            ctl.dst = snh_pkg::DST_H;
         end
         snh_pkg::ST_J_SHL10: begin
            ctl.op    = snh_pkg::ALU_ADD_SHL;
            ctl.shamt = snh_pkg::SH_JENKINS_ADD;
            ctl.dst   = snh_pkg::DST_H;
         end
         snh_pkg::ST_J_SHR6: begin
            ctl.shamt = snh_pkg::SH_JENKINS_XOR;
            ctl.dst   = snh_pkg::DST_H;
         end
         snh_pkg::ST_D_SHL5: begin
            ctl.op    = snh_pkg::ALU_ADD_SHL;
            ctl.shamt = snh_pkg::SH_XOR33;
            ctl.dst   = snh_pkg::DST_H;
         end
         snh_pkg::ST_D_XORB: begin
            ctl.op  = snh_pkg::ALU_XOR_B;
            ctl.dst = snh_pkg::DST_H;
         end
         snh_pkg::ST_M_K1LO, snh_pkg::ST_M_K2LO: begin
            ctl.op  = snh_pkg::ALU_MUL_LO;
            ctl.src = snh_pkg::SRC_K;
            ctl.dst = snh_pkg::DST_P;
         end
         snh_pkg::ST_M_K1HI, snh_pkg::ST_M_K2HI: begin
            ctl.op   = snh_pkg::ALU_MUL_HI;
            ctl.src  = snh_pkg::SRC_K;
            ctl.bsel = snh_pkg::BSEL_P;
            ctl.dst  = snh_pkg::DST_K;
         end
         snh_pkg::ST_M_K24: begin
            ctl.src   = snh_pkg::SRC_K;
            ctl.shamt = snh_pkg::SH_MURMUR_K;
            ctl.dst   = snh_pkg::DST_K;
         end
         snh_pkg::ST_M_HLO, snh_pkg::ST_F1_LO: begin
            ctl.op  = snh_pkg::ALU_MUL_LO;
            ctl.dst = snh_pkg::DST_P;
         end
         snh_pkg::ST_M_HHI, snh_pkg::ST_F1_HI: begin
            ctl.op   = snh_pkg::ALU_MUL_HI;
            ctl.bsel = snh_pkg::BSEL_P;
            ctl.dst  = snh_pkg::DST_H;
         end
         snh_pkg::ST_M_HXK: begin
            ctl.op    = snh_pkg::ALU_XOR_B;
            ctl.bsel  = snh_pkg::BSEL_K;
            ctl.dst   = snh_pkg::DST_H;
            ctl.clr_k = 1'b1;
         end
         snh_pkg::ST_F0_SHL3: begin
            ctl.op    = snh_pkg::ALU_ADD_SHL;
            ctl.shamt = snh_pkg::SH_JENKINS_FIN_A;
            ctl.dst   = snh_pkg::DST_H;
         end
         snh_pkg::ST_F0_SHR11: begin
            ctl.shamt = snh_pkg::SH_JENKINS_FIN_B;
            ctl.dst   = snh_pkg::DST_H;
         end
         snh_pkg::ST_F0_SHL15: begin
            ctl.op    = snh_pkg::ALU_ADD_SHL;
            ctl.shamt = snh_pkg::SH_JENKINS_FIN_C;
            ctl.dst   = snh_pkg::DST_H;
         end
         snh_pkg::ST_F1_SHR13: begin
            ctl.shamt = snh_pkg::SH_MURMUR_FIN_A;
            ctl.dst   = snh_pkg::DST_H;
         end
         snh_pkg::ST_F1_SHR15: begin
            ctl.shamt = snh_pkg::SH_MURMUR_FIN_B;
            ctl.dst   = snh_pkg::DST_H;
         end
         snh_pkg::ST_DONE: ctl.load_out = status.out_free;
         default: idle = 1'b0;
      endcase
   end

endmodule

// File: verif/selectable_name_hash_tb.sv
module selectable_name_hash_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  CFG_XOR33      = 2'd2;
   localparam logic [1:0]  CFG_RESERVED   = 2'd3;
   localparam int          HASHED_LIMIT   = 64;
   localparam int          MURMUR_LIMIT   = (HASHED_LIMIT + 7) / 8 * 8;
   localparam logic [63:0] MUR_M          = {32'd0, snh_pkg::MURMUR_M};
   localparam int          DRAIN_CYCLES   = 40;
   localparam int          STALL_LIMIT    = 2000;
   localparam int          PHASE_COUNT    = 12;
   localparam int          PHASE_REQUESTS = 110;

   class name_hash_scoreboard;
      logic [1:0]        mode_reg;
      snh_pkg::mode_type name_mode;
      logic [15:0]       open_length;
      logic [63:0]       acc;
      logic [63:0]       gather;
      int unsigned       taken;
      bit                open;
      logic [63:0]       expected_hashes[$];
      int                errors;

      function new();
         mode_reg = snh_pkg::CSR_MODE_JENKINS;
         name_mode = snh_pkg::MODE_JENKINS;
         open_length = '0;
         acc = '0;
         gather = '0;
         taken = 0;
         open = 1'b0;
         errors = 0;
      endfunction

      function void write_mode(input logic [1:0] value);
         mode_reg = value;
      endfunction

      function int pending();
         return expected_hashes.size();
      endfunction

      function void mix_murmur_word();
         logic [63:0] k;
         k = gather * MUR_M;
         k = k ^ (k >> snh_pkg::SH_MURMUR_K);
         k = k * MUR_M;
         acc = acc * MUR_M;
         acc = acc ^ k;
         gather = '0;
      endfunction

      function void absorb_byte(input logic [7:0] b);
         logic [63:0] h;
         h = acc;
         case (name_mode)
            snh_pkg::MODE_JENKINS: begin
               h = h + {56'd0, b};
               h = h + (h << snh_pkg::SH_JENKINS_ADD);
               h = h ^ (h >> snh_pkg::SH_JENKINS_XOR);
               acc = h;
            end
            snh_pkg::MODE_MURMUR: begin
               gather = gather | ({56'd0, b} << (8 * (taken % 8)));
            end
            default: begin
               acc = ((h << snh_pkg::SH_XOR33) + h) ^ {56'd0, b};
            end
         endcase
         taken++;
         if (name_mode == snh_pkg::MODE_MURMUR && taken % 8 == 0)
            mix_murmur_word();
      endfunction

      function logic [63:0] finalize_hash();
         logic [63:0] h;
         case (name_mode)
            snh_pkg::MODE_JENKINS: begin
               h = acc;
               h = h + (h << snh_pkg::SH_JENKINS_FIN_A);
               h = h ^ (h >> snh_pkg::SH_JENKINS_FIN_B);
               h = h + (h << snh_pkg::SH_JENKINS_FIN_C);
            end
            snh_pkg::MODE_MURMUR: begin
               if (taken % 8 != 0)
                  mix_murmur_word();
               h = acc;
               h = h ^ (h >> snh_pkg::SH_MURMUR_FIN_A);
               h = h * MUR_M;
               h = h ^ (h >> snh_pkg::SH_MURMUR_FIN_B);
            end
            default: begin
               h = acc;
            end
         endcase
         return h;
      endfunction

      function void note_request(input logic [15:0] len, input logic [7:0] b,
                                 input logic bv, input logic last);
         int unsigned limit;
         if (!open) begin
            open = 1'b1;
            if (mode_reg == snh_pkg::CSR_MODE_JENKINS)
               name_mode = snh_pkg::MODE_JENKINS;
            else if (mode_reg == snh_pkg::CSR_MODE_MURMUR)
               name_mode = snh_pkg::MODE_MURMUR;
            else
               name_mode = snh_pkg::MODE_XOR33;
            open_length = len;
            taken = 0;
            gather = '0;
            acc = (name_mode == snh_pkg::MODE_MURMUR) ? (MUR_M ^ {48'd0, len}) : '0;
         end
         limit = (name_mode == snh_pkg::MODE_MURMUR) ? MURMUR_LIMIT : HASHED_LIMIT;
         if (bv && taken < open_length && taken < limit)
            absorb_byte(b);
         if (last) begin
            expected_hashes.push_back(finalize_hash());
            open = 1'b0;
            taken = 0;
            gather = '0;
            acc = '0;
         end
      endfunction

      function void check_result(input logic [63:0] actual);
         logic [63:0] expected;
         if (expected_hashes.size() == 0) begin
            $display("%0t: name hash %h arrived with none expected", $time, actual);
            errors++;
         end else begin
            expected = expected_hashes.pop_front();
            if (actual !== expected) begin
               $display("%0t: name hash mismatch, expected %h, actual %h",
                        $time, expected, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_name_length = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_byte_valid = 1'b0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_name_hash;

   name_hash_scoreboard sb;
   bit          idle_on = 1'b0;
   int          requests_sent = 0;
   int          idle_cycles = 0;

   selectable_name_hash dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_name_length (req_name_length),
      .req_data_byte   (req_data_byte),
      .req_byte_valid  (req_byte_valid),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_name_hash   (rsp_name_hash)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable)
            sb.write_mode(csr_write_data);
         if (req_valid && !req_stall)
            sb.note_request(req_name_length, req_data_byte, req_byte_valid, req_last_byte);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_name_hash);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("selectable_name_hash test failed");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_request(input logic [15:0] len, input logic [7:0] b,
                               input logic bv, input logic last);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_name_length <= len;
      req_data_byte <= b;
      req_byte_valid <= bv;
      req_last_byte <= last;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
      @(negedge clock);
      if (bv || last)
         requests_sent++;
   endtask

   task automatic send_name(input logic [15:0] len, input int nbytes,
                            input bit last_on_byte, input int noise_pct);
      for (int i = 0; i < nbytes; i++) begin
         if (noise_pct > 0 && $urandom_range(1, 100) <= noise_pct)
            send_request(len, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_request(len, 8'($urandom_range(0, 255)), 1'b1,
                      last_on_byte && i == nbytes - 1);
      end
      if (!last_on_byte || nbytes == 0)
         send_request(len, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic hold_until_drained(input int extra);
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_hash_mode(input logic [1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random_name();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         len = $urandom_range(1, 20);
         send_name(16'(len), len, 1'b1, 0);
      end else if (pick < 80) begin
         len = $urandom_range(60, 72);
         send_name(16'(len), len, 1'b1, 0);
      end else if (pick < 88) begin
         send_name(16'($urandom_range(0, 65535)), $urandom_range(0, 12), 1'b0, 0);
      end else if (pick < 94) begin
         len = $urandom_range(0, 10);
         send_name(16'(len), len + int'($urandom_range(1, 6)),
                   1'($urandom_range(0, 1)), 0);
      end else begin
         len = $urandom_range(0, 16);
         send_name(16'(len), len, 1'($urandom_range(0, 1)), 30);
      end
   endtask

   initial begin
      int phase_end;
      bit paused;
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;

      write_hash_mode(snh_pkg::CSR_MODE_JENKINS);
      send_request(16'd0, 8'h00, 1'b0, 1'b1);
      send_request(16'd3, 8'hFF, 1'b1, 1'b0);
      send_request(16'd3, 8'h00, 1'b1, 1'b0);
      send_request(16'd3, 8'hA5, 1'b1, 1'b1);
      send_name(16'd2, 4, 1'b1, 0);
      hold_until_drained(DRAIN_CYCLES);

      write_hash_mode(snh_pkg::CSR_MODE_MURMUR);
      send_request(16'd0, 8'hFF, 1'b0, 1'b1);
      send_name(16'd5, 5, 1'b1, 0);
      send_name(16'd8, 8, 1'b1, 0);
      hold_until_drained(DRAIN_CYCLES);

      write_hash_mode(CFG_XOR33);
      send_name(16'd2, 2, 1'b1, 0);
      send_name(16'hFFFF, 1, 1'b0, 0);
      hold_until_drained(DRAIN_CYCLES);

      write_hash_mode(CFG_RESERVED);
      send_name(16'd1, 1, 1'b1, 0);
      hold_until_drained(DRAIN_CYCLES);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         idle_on = (phase < PHASE_COUNT - 2) ? ($urandom_range(0, 3) != 0) : 1'b0;
         if (phase < 4)
            write_hash_mode(2'(phase));
         else
            write_hash_mode(2'($urandom_range(0, 3)));
         phase_end = requests_sent + PHASE_REQUESTS;
         paused = 1'b0;
         while (requests_sent < phase_end) begin
            send_random_name();
            if (!paused && requests_sent >= phase_end - PHASE_REQUESTS / 2) begin
               hold_until_drained(0);
               paused = 1'b1;
            end
         end
         hold_until_drained(DRAIN_CYCLES);
      end

      if (sb.pending() != 0) begin
         $display("%0t: %0d name hash results missing, oldest expected %h, actual none",
                  $time, sb.pending(), sb.expected_hashes[0]);
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("selectable_name_hash test passed");
      else
         $display("selectable_name_hash test failed");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/snh_pkg.sv
hw/rtl/snh_alu.sv
hw/rtl/snh_seq.sv
hw/rtl/selectable_name_hash.sv
verif/selectable_name_hash_tb.sv
